// ===== rtl/core/bpa_pkg.sv =====
// Shared constants, types and codes of the bitmap page allocator.
// Used by the channel interfaces, the map RAM, the engine and the top level.
package bpa_pkg;

    localparam int MAP_WORDS     = 1024;
    localparam int PAGE_BYTES    = 4096;
    localparam int MAX_REGIONS   = 64;
    localparam int WORD_BITS     = 64;
    localparam int POOL_MIN_ADDR = 32'h0010_0000;

    localparam int ADDR_W  = 52;
    localparam int SIZE_W  = 48;
    localparam int PA_W    = 53;
    localparam int CNT_W   = 64;
    localparam int ACT_W   = 2;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LIMIT      = MAP_WORDS * WORD_BITS;
    localparam int PIDX_W     = $clog2(LIMIT);
    localparam int PEND_W     = PIDX_W + 1;
    localparam int PCNT_W     = SIZE_W - PAGE_SHIFT + 1;
    localparam int RC_W       = $clog2(MAX_REGIONS + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RESERVE = 2'd2,
        ACT_ADD     = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_RES_CALC,
        ST_RES_SPAN,
        ST_RES_RD,
        ST_RES_WR,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 we;
        logic [WIDX_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [WIDX_W-1:0]    raddr;
    } ram_req_t;

endpackage

// ===== rtl/core/bpa_if.sv =====
// Valid/ready channel interfaces for command words and result words.
// Depends on bpa_pkg for field widths.
interface bpa_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::ACT_W-1:0]     action;
    logic [bpa_pkg::ADDR_W-1:0]    address;
    logic [bpa_pkg::SIZE_W-1:0]    byte_count;

    modport source (output valid, action, address, byte_count, input ready);
    modport sink   (input valid, action, address, byte_count, output ready);
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::PA_W-1:0]      page_address;
    logic                          out_of_memory;
    logic [bpa_pkg::CNT_W-1:0]     free_bytes;
    logic [bpa_pkg::CNT_W-1:0]     used_bytes;
    logic [bpa_pkg::CNT_W-1:0]     total_bytes;

    modport source (output valid, page_address, out_of_memory, free_bytes, used_bytes,
                    total_bytes, input ready);
    modport sink   (input valid, page_address, out_of_memory, free_bytes, used_bytes,
                    total_bytes, output ready);
endinterface

// ===== rtl/core/bitmap_page_allocator.sv =====
// Channel   | dir | words
// cmd       | in  | action, address, byte_count
// rsp       | out | page_address, out_of_memory, free_bytes, used_bytes, total_bytes
//
// Top level of the bitmap page allocator: map RAM plus sequencer.
// Depends on bpa_pkg, bpa_if, bpa_map_ram and bpa_engine.
// After reset the map is filled with ones, one word a cycle, with cmd.ready
// low meanwhile. Free reads and rewrites at most one map word, reserve each
// map word it touches. Allocate scans one map word a cycle through the RAM
// read port up to the first word with a free page. A finished result sits in
// the rsp register; a new word is taken meanwhile, and the engine waits at
// its end only if rsp is still stalled.
module bitmap_page_allocator (
    input  logic      clk,
    input  logic      rst_n,
    bpa_cmd_if.sink   cmd,
    bpa_rsp_if.source rsp
);

    bpa_pkg::ram_req_t             ram_req;
    logic [bpa_pkg::WORD_BITS-1:0] ram_rdata;

    bpa_map_ram u_map (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    bpa_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

// ===== rtl/core/bpa_map_ram.sv =====
// Free map storage: one write port, one read port, registered read data.
// Depends on bpa_pkg for depth, width and the request struct.
module bpa_map_ram (
    input  logic                          clk,
    input  bpa_pkg::ram_req_t             req,
    output logic [bpa_pkg::WORD_BITS-1:0] rdata
);

    logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::MAP_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ===== rtl/core/bpa_engine.sv =====
// Sequencer of the allocator: read-modify-write of free map words, byte
// counters, pool base and the result register. Depends on bpa_pkg and bpa_if.
module bpa_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    bpa_cmd_if.sink                       cmd,
    bpa_rsp_if.source                     rsp,
    output bpa_pkg::ram_req_t             ram_req,
    input  logic [bpa_pkg::WORD_BITS-1:0] ram_rdata
);

    localparam logic [bpa_pkg::WIDX_W-1:0]    LAST_WORD = bpa_pkg::WIDX_W'(bpa_pkg::MAP_WORDS - 1);
    localparam logic [bpa_pkg::PEND_W-1:0]    LIMIT_P   = bpa_pkg::PEND_W'(bpa_pkg::LIMIT);
    localparam logic [bpa_pkg::WORD_BITS-1:0] ONES      = '1;
    localparam logic [bpa_pkg::BIT_W-1:0]     TOP_BIT   = bpa_pkg::BIT_W'(bpa_pkg::WORD_BITS - 1);

    bpa_pkg::state_t                  state_reg, state_next;
    bpa_pkg::action_t                 act_reg, act_next;
    logic [bpa_pkg::WIDX_W-1:0]       widx_reg, widx_next;
    logic [bpa_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic [bpa_pkg::SIZE_W-1:0]       size_reg, size_next;
    logic [bpa_pkg::ADDR_W-1:0]       base_reg, base_next;
    logic [bpa_pkg::RC_W-1:0]         rcnt_reg, rcnt_next;
    logic [bpa_pkg::CNT_W-1:0]        total_reg, total_next;
    logic [bpa_pkg::CNT_W-1:0]        free_reg, free_next;
    logic [bpa_pkg::CNT_W-1:0]        used_reg, used_next;
    logic [bpa_pkg::PEND_W-1:0]       start_reg, start_next;
    logic [bpa_pkg::PEND_W-1:0]       end_reg, end_next;
    logic [bpa_pkg::PCNT_W-1:0]       pcnt_reg, pcnt_next;
    logic                             rok_reg, rok_next;
    logic [bpa_pkg::PA_W-1:0]         pa_reg, pa_next;
    logic                             oom_reg, oom_next;
    logic                             ovalid_reg, ovalid_next;
    logic [bpa_pkg::PA_W-1:0]         opa_reg, opa_next;
    logic                             ooom_reg, ooom_next;
    logic [bpa_pkg::CNT_W-1:0]        ofree_reg, ofree_next;
    logic [bpa_pkg::CNT_W-1:0]        oused_reg, oused_next;
    logic [bpa_pkg::CNT_W-1:0]        ototal_reg, ototal_next;

    // offset of the held address from the pool base, borrow on top
    logic [bpa_pkg::ADDR_W:0]         off;
    logic                             page_ok;
    logic [bpa_pkg::PIDX_W-1:0]       page;
    logic [bpa_pkg::BIT_W-1:0]        low_bit;
    logic [bpa_pkg::PIDX_W-1:0]       alloc_page;
    logic [bpa_pkg::PEND_W-1:0]       room;
    logic [bpa_pkg::PEND_W-1:0]       last_page;
    logic [bpa_pkg::WIDX_W-1:0]       first_word;
    logic [bpa_pkg::WIDX_W-1:0]       end_word;
    logic [bpa_pkg::BIT_W-1:0]        lo_bit;
    logic [bpa_pkg::BIT_W-1:0]        hi_bit;
    logic [bpa_pkg::WORD_BITS-1:0]    clr_mask;

    function automatic logic [bpa_pkg::BIT_W-1:0] lowest_set(
        input logic [bpa_pkg::WORD_BITS-1:0] w
    );
        logic [bpa_pkg::BIT_W-1:0] b;
        b = '0;
        for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                b = bpa_pkg::BIT_W'(i);
            end
        end
        return b;
    endfunction

    assign off        = {1'b0, addr_reg} - {1'b0, base_reg};
    assign page_ok    = !off[bpa_pkg::ADDR_W] &&
                        (off[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT+bpa_pkg::PIDX_W] == '0);
    assign page       = off[bpa_pkg::PAGE_SHIFT +: bpa_pkg::PIDX_W];
    assign low_bit    = lowest_set(ram_rdata);
    assign alloc_page = {widx_reg, low_bit};
    assign room       = LIMIT_P - start_reg;
    assign last_page  = end_reg - bpa_pkg::PEND_W'(1);
    assign first_word = start_reg[bpa_pkg::BIT_W +: bpa_pkg::WIDX_W];
    assign end_word   = last_page[bpa_pkg::BIT_W +: bpa_pkg::WIDX_W];
    assign lo_bit     = (widx_reg == first_word) ? start_reg[bpa_pkg::BIT_W-1:0] : '0;
    assign hi_bit     = (widx_reg == end_word) ? last_page[bpa_pkg::BIT_W-1:0] : TOP_BIT;
    assign clr_mask   = (ONES << lo_bit) & (ONES >> (TOP_BIT - hi_bit));

    assign cmd.ready         = (state_reg == bpa_pkg::ST_IDLE);
    assign rsp.valid         = ovalid_reg;
    assign rsp.page_address  = opa_reg;
    assign rsp.out_of_memory = ooom_reg;
    assign rsp.free_bytes    = ofree_reg;
    assign rsp.used_bytes    = oused_reg;
    assign rsp.total_bytes   = ototal_reg;

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        widx_next   = widx_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        base_next   = base_reg;
        rcnt_next   = rcnt_reg;
        total_next  = total_reg;
        free_next   = free_reg;
        used_next   = used_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        pcnt_next   = pcnt_reg;
        rok_next    = rok_reg;
        pa_next     = pa_reg;
        oom_next    = oom_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        opa_next    = opa_reg;
        ooom_next   = ooom_reg;
        ofree_next  = ofree_reg;
        oused_next  = oused_reg;
        ototal_next = ototal_reg;
        ram_req     = '{we: 1'b0, waddr: widx_reg, wdata: ram_rdata, raddr: widx_reg};

        case (state_reg)
            bpa_pkg::ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ONES;
                widx_next     = widx_reg + bpa_pkg::WIDX_W'(1);
                if (widx_reg == LAST_WORD)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    act_next  = bpa_pkg::action_t'(cmd.action);
                    addr_next = cmd.address;
                    size_next = cmd.byte_count;
                    pa_next   = '0;
                    oom_next  = 1'b0;
                    widx_next = '0;
                    case (bpa_pkg::action_t'(cmd.action))
                        bpa_pkg::ACT_ALLOC:   state_next = bpa_pkg::ST_ALLOC_RD;
                        bpa_pkg::ACT_FREE:    state_next = bpa_pkg::ST_FREE_RD;
                        bpa_pkg::ACT_RESERVE: state_next = bpa_pkg::ST_RES_CALC;
                        default:              state_next = bpa_pkg::ST_ADD;
                    endcase
                end
            end
            bpa_pkg::ST_ALLOC_RD:
            begin
                state_next = bpa_pkg::ST_ALLOC_CHK;
            end
            bpa_pkg::ST_ALLOC_CHK:
            begin
                // next word is fetched while this one is checked
                ram_req.raddr = widx_reg + bpa_pkg::WIDX_W'(1);
                if (ram_rdata != '0)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = ram_rdata & ~(bpa_pkg::WORD_BITS'(1) << low_bit);
                    free_next     = free_reg - bpa_pkg::CNT_W'(bpa_pkg::PAGE_BYTES);
                    used_next     = used_reg + bpa_pkg::CNT_W'(bpa_pkg::PAGE_BYTES);
                    pa_next       = {1'b0, base_reg} +
                                    (bpa_pkg::PA_W'(alloc_page) << bpa_pkg::PAGE_SHIFT);
                    state_next    = bpa_pkg::ST_DONE;
                end
                else if (widx_reg == LAST_WORD)
                begin
                    oom_next   = 1'b1;
                    state_next = bpa_pkg::ST_DONE;
                end
                else
                begin
                    widx_next = widx_reg + bpa_pkg::WIDX_W'(1);
                end
            end
            bpa_pkg::ST_FREE_RD:
            begin
                ram_req.raddr = page[bpa_pkg::BIT_W +: bpa_pkg::WIDX_W];
                widx_next     = page[bpa_pkg::BIT_W +: bpa_pkg::WIDX_W];
                start_next    = bpa_pkg::PEND_W'(page);
                state_next    = page_ok ? bpa_pkg::ST_FREE_WR : bpa_pkg::ST_DONE;
            end
            bpa_pkg::ST_FREE_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ram_rdata |
                                (bpa_pkg::WORD_BITS'(1) << start_reg[bpa_pkg::BIT_W-1:0]);
                free_next     = free_reg + bpa_pkg::CNT_W'(bpa_pkg::PAGE_BYTES);
                used_next     = used_reg - bpa_pkg::CNT_W'(bpa_pkg::PAGE_BYTES);
                state_next    = bpa_pkg::ST_DONE;
            end
            bpa_pkg::ST_RES_CALC:
            begin
                start_next = bpa_pkg::PEND_W'(page);
                rok_next   = page_ok;
                pcnt_next  = bpa_pkg::PCNT_W'(({1'b0, size_reg} +
                             (bpa_pkg::SIZE_W + 1)'(bpa_pkg::PAGE_BYTES - 1))
                             >> bpa_pkg::PAGE_SHIFT);
                state_next = (base_reg == '0) ? bpa_pkg::ST_DONE : bpa_pkg::ST_RES_SPAN;
            end
            bpa_pkg::ST_RES_SPAN:
            begin
                used_next  = used_reg + bpa_pkg::CNT_W'(size_reg);
                free_next  = free_reg - bpa_pkg::CNT_W'(size_reg);
                end_next   = (pcnt_reg > bpa_pkg::PCNT_W'(room)) ? LIMIT_P :
                             start_reg + bpa_pkg::PEND_W'(pcnt_reg);
                widx_next  = first_word;
                state_next = (rok_reg && pcnt_reg != '0) ? bpa_pkg::ST_RES_RD :
                             bpa_pkg::ST_DONE;
            end
            bpa_pkg::ST_RES_RD:
            begin
                state_next = bpa_pkg::ST_RES_WR;
            end
            bpa_pkg::ST_RES_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ram_rdata & ~clr_mask;
                widx_next     = widx_reg + bpa_pkg::WIDX_W'(1);
                state_next    = (widx_reg == end_word) ? bpa_pkg::ST_DONE :
                                bpa_pkg::ST_RES_RD;
            end
            bpa_pkg::ST_ADD:
            begin
                if (rcnt_reg < bpa_pkg::RC_W'(bpa_pkg::MAX_REGIONS))
                begin
                    rcnt_next  = rcnt_reg + bpa_pkg::RC_W'(1);
                    total_next = total_reg + bpa_pkg::CNT_W'(size_reg);
                    free_next  = free_reg + bpa_pkg::CNT_W'(size_reg);
                    if (base_reg == '0 &&
                        addr_reg >= bpa_pkg::ADDR_W'(bpa_pkg::POOL_MIN_ADDR))
                    begin
                        base_next = addr_reg;
                    end
                end
                state_next = bpa_pkg::ST_DONE;
            end
            bpa_pkg::ST_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    opa_next    = pa_reg;
                    ooom_next   = oom_reg;
                    ofree_next  = free_reg;
                    oused_next  = used_reg;
                    ototal_next = total_reg;
                    state_next  = bpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bpa_pkg::ST_CLEAR;
            widx_reg   <= '0;
            base_reg   <= '0;
            rcnt_reg   <= '0;
            total_reg  <= '0;
            free_reg   <= '0;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            widx_reg   <= widx_next;
            base_reg   <= base_next;
            rcnt_reg   <= rcnt_next;
            total_reg  <= total_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        addr_reg   <= addr_next;
        size_reg   <= size_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        pcnt_reg   <= pcnt_next;
        rok_reg    <= rok_next;
        pa_reg     <= pa_next;
        oom_reg    <= oom_next;
        opa_reg    <= opa_next;
        ooom_reg   <= ooom_next;
        ofree_reg  <= ofree_next;
        oused_reg  <= oused_next;
        ototal_reg <= ototal_next;
    end

endmodule

// ===== rtl/core/bpa_checker.sv =====
// Port-level checks of the allocator, bound to the top level.
// Depends on bpa_pkg for field widths.
module bpa_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [bpa_pkg::PA_W-1:0]   page_address,
    input logic                       out_of_memory,
    input logic [bpa_pkg::CNT_W-1:0]  total_bytes
);

    // out of memory never comes with an address
    a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_of_memory |-> page_address == '0)
        else $error("out_of_memory with nonzero page_address");

    // one word at a time: busy right after taking a command
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in progress");

    // a result appears only when the engine was busy the cycle before
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!cmd_ready))
        else $error("result without work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(page_address) &&
        $stable(total_bytes))
        else $error("stalled result changed");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .page_address  (rsp.page_address),
    .out_of_memory (rsp.out_of_memory),
    .total_bytes   (rsp.total_bytes)
);

// ===== sim/tb.sv =====
// Self-checking testbench of bitmap_page_allocator: directed and random command words.
// Depends on bpa_pkg, bpa_if and the allocator RTL; a scoreboard class predicts each result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    typedef struct {
        logic [PA_W-1:0]  page_address;
        logic             out_of_memory;
        logic [CNT_W-1:0] free_bytes;
        logic [CNT_W-1:0] used_bytes;
        logic [CNT_W-1:0] total_bytes;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [WORD_BITS-1:0] page_map [MAP_WORDS];
        logic [63:0]          base_addr;
        int unsigned          regions;
        logic [63:0]          total_cnt;
        logic [63:0]          free_cnt;
        logic [63:0]          used_cnt;
        alloc_result_t        pending [$];
        int unsigned          errors;
        int unsigned          checked;
        int unsigned          oom_seen;

        function new();
            foreach (page_map[i])
                page_map[i] = '1;
            base_addr = 0;
            regions   = 0;
            total_cnt = 0;
            free_cnt  = 0;
            used_cnt  = 0;
            errors    = 0;
            checked   = 0;
            oom_seen  = 0;
        endfunction

        function void note_command(action_t act, logic [ADDR_W-1:0] addr,
                                   logic [SIZE_W-1:0] size);
            alloc_result_t r;
            logic [63:0] a64, s64, start, cnt, stop, pg;
            a64 = 64'(addr);
            s64 = 64'(size);
            r.page_address  = '0;
            r.out_of_memory = 1'b0;
            case (act)
                ACT_ALLOC:
                begin
                    r.out_of_memory = 1'b1;
                    for (int w = 0; w < MAP_WORDS; w++)
                    begin
                        if (page_map[w] != '0)
                        begin
                            int b;
                            b = 0;
                            while (b < 63 && !page_map[w][b])
                                b++;
                            page_map[w][b] = 1'b0;
                            free_cnt -= PAGE_BYTES;
                            used_cnt += PAGE_BYTES;
                            pg = base_addr + (64'(w) * WORD_BITS + 64'(b)) * PAGE_BYTES;
                            r.page_address  = pg[PA_W-1:0];
                            r.out_of_memory = 1'b0;
                            break;
                        end
                    end
                    if (r.out_of_memory)
                        oom_seen++;
                end
                ACT_FREE:
                begin
                    if (a64 >= base_addr)
                    begin
                        pg = (a64 - base_addr) / PAGE_BYTES;
                        if (pg / WORD_BITS < MAP_WORDS)
                        begin
                            page_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b1;
                            free_cnt += PAGE_BYTES;
                            used_cnt -= PAGE_BYTES;
                        end
                    end
                end
                ACT_RESERVE:
                begin
                    if (base_addr != 0)
                    begin
                        start = (a64 - base_addr) / PAGE_BYTES;
                        cnt   = (s64 + PAGE_BYTES - 1) / PAGE_BYTES;
                        if (start < LIMIT)
                        begin
                            stop = (cnt > LIMIT - start) ? LIMIT : start + cnt;
                            for (pg = start; pg < stop; pg++)
                                page_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b0;
                        end
                        used_cnt += s64;
                        free_cnt -= s64;
                    end
                end
                default:
                begin
                    if (regions < MAX_REGIONS)
                    begin
                        regions++;
                        total_cnt += s64;
                        free_cnt  += s64;
                        if (base_addr == 0 && a64 >= POOL_MIN_ADDR)
                            base_addr = a64;
                    end
                end
            endcase
            r.free_bytes  = free_cnt;
            r.used_bytes  = used_cnt;
            r.total_bytes = total_cnt;
            pending.push_back(r);
        endfunction

        function void check_result(alloc_result_t act);
            alloc_result_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (act.page_address !== exp.page_address)
            begin
                $display("%0t: page_address exp %h act %h", $time,
                         exp.page_address, act.page_address);
                errors++;
            end
            if (act.out_of_memory !== exp.out_of_memory)
            begin
                $display("%0t: out_of_memory exp %b act %b", $time,
                         exp.out_of_memory, act.out_of_memory);
                errors++;
            end
            if (act.free_bytes !== exp.free_bytes)
            begin
                $display("%0t: free_bytes exp %h act %h", $time,
                         exp.free_bytes, act.free_bytes);
                errors++;
            end
            if (act.used_bytes !== exp.used_bytes)
            begin
                $display("%0t: used_bytes exp %h act %h", $time,
                         exp.used_bytes, act.used_bytes);
                errors++;
            end
            if (act.total_bytes !== exp.total_bytes)
            begin
                $display("%0t: total_bytes exp %h act %h", $time,
                         exp.total_bytes, act.total_bytes);
                errors++;
            end
        endfunction
    endclass

    localparam logic [ADDR_W-1:0] POOL_BASE = ADDR_W'(POOL_MIN_ADDR);
    localparam int                WATCHDOG  = 20000;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   idle_cycles;
    int   sent;

    bpa_cmd_if cmd ();
    bpa_rsp_if rsp ();

    bitmap_page_allocator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    alloc_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic send_word(action_t act, logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.action     <= act;
        cmd.address    <= addr;
        cmd.byte_count <= size;
        do
            @(posedge clk);
        while (!cmd.ready);
        sb.note_command(act, addr, size);
        sent++;
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr52();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size48();
        return SIZE_W'({$urandom, $urandom});
    endfunction

    // Address near the pool: mostly inside, some past the end, some below the base.
    function automatic logic [ADDR_W-1:0] pool_addr();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return rand_addr52();
        if (sel == 1)
            return ADDR_W'($urandom_range(0, POOL_MIN_ADDR - 1));
        return POOL_BASE + ADDR_W'($urandom_range(0, LIMIT + 64)) * PAGE_BYTES
               + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
    endfunction

    task automatic run_directed();
        // no base yet: reserve is a no-op, alloc counts from address zero
        send_word(ACT_RESERVE, POOL_BASE, SIZE_W'(PAGE_BYTES));
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_FREE, '0, '0);
        send_word(ACT_ADD, '0, SIZE_W'(PAGE_BYTES));
        send_word(ACT_ADD, POOL_BASE - 1, '1);
        send_word(ACT_ADD, POOL_BASE, SIZE_W'(LIMIT) * PAGE_BYTES);
        send_word(ACT_ADD, '1, '0);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_FREE, POOL_BASE + PAGE_BYTES + 7, '0);
        send_word(ACT_FREE, POOL_BASE + 5 * PAGE_BYTES, '0);
        send_word(ACT_FREE, POOL_BASE - 1, '0);
        send_word(ACT_FREE, POOL_BASE + ADDR_W'(LIMIT) * PAGE_BYTES, '0);
        send_word(ACT_FREE, '1, '0);
        send_word(ACT_RESERVE, POOL_BASE - PAGE_BYTES, SIZE_W'(PAGE_BYTES));
        send_word(ACT_RESERVE, POOL_BASE + ADDR_W'(LIMIT) * PAGE_BYTES, '1);
        send_word(ACT_RESERVE, POOL_BASE + 3, '0);
        send_word(ACT_RESERVE, POOL_BASE + 64 * PAGE_BYTES, 1);
        // clear the whole map, then out of memory, then recover one page
        send_word(ACT_RESERVE, POOL_BASE, '1);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_FREE, POOL_BASE + 70 * PAGE_BYTES, '0);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_FREE, POOL_BASE + ADDR_W'(LIMIT - 1) * PAGE_BYTES, '0);
        send_word(ACT_ALLOC, '0, '0);
    endtask

    task automatic run_random(int n);
        int unsigned sel;
        logic [SIZE_W-1:0] sz;
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                sz = rand_size48();
            else
                sz = SIZE_W'($urandom_range(0, 64 * PAGE_BYTES));
            if (sel < 30)
                send_word(ACT_ALLOC, rand_addr52(), rand_size48());
            else if (sel < 70)
                send_word(ACT_FREE, pool_addr(), rand_size48());
            else if (sel < 88)
                send_word(ACT_RESERVE, pool_addr(), sz);
            else
                send_word(ACT_ADD, rand_addr52(), sz);
        end
    endtask

    // result side
    initial
    begin
        alloc_result_t r;
        int gap;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            r.page_address  = rsp.page_address;
            r.out_of_memory = rsp.out_of_memory;
            r.free_bytes    = rsp.free_bytes;
            r.used_bytes    = rsp.used_bytes;
            r.total_bytes   = rsp.total_bytes;
            sb.check_result(r);
        end
    end

    // watchdog: cycles with no word moved on either channel
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("%0t: watchdog expired, no word moved", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        sent = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cmd.valid <= 1'b0;
        cmd.action <= ACT_ALLOC;
        cmd.address <= '0;
        cmd.byte_count <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(725);
        cmd.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d command words, checked %0d results, %0d out-of-memory allocs.",
                 sent, sb.checked, sb.oom_seen);
        $display("Regions added: %0d, pool base %h, mismatches: %0d.",
                 sb.regions, sb.base_addr, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
